[hdl/contiguous_block_run_allocator_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the block run allocator
// Implication checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_BLOCK_RUN_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_BLOCK_RUN_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CRBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CRBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CRBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CRBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/crba_pkg.sv]
// ----------------------------------------------------------------------------
// crba_pkg
// Shared types and codes of the block run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package crba_pkg;

   localparam int DEF_BLOCK_SIZE_LOG = 22;
   localparam int DEF_NUM_BLOCKS     = 1024;
   localparam int FIRST_FREE_BLOCK   = 2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] ST_ALLOC_OK  = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_FREE_DONE = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WINDOW,
      S_PROBE,
      S_MARK,
      S_FREE,
      S_DONE
   } seq_state_type;

   // bitmap port control
   typedef struct packed {
      logic wr_en;
      logic wr_bit;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

[hdl/crba_bitmap.sv]
// ----------------------------------------------------------------------------
// crba_bitmap
// Busy bitmap, one bit per block, single port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crba_bitmap
   import crba_pkg::*;
#(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
   localparam int IDX_W = $clog2(NUM_BLOCKS)
) (
   input  wire logic             clock,
   input  wire mem_ctl_type      mem_ctl,
   input  wire logic [IDX_W-1:0] mem_addr,
   output logic                  mem_rd_bit
);

   logic map_mem [NUM_BLOCKS];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         map_mem[mem_addr] <= mem_ctl.wr_bit;
      end
      if (mem_ctl.rd_en) begin
         rd_bit_ff <= map_mem[mem_addr];
      end
   end

   assign mem_rd_bit = rd_bit_ff;

endmodule

`default_nettype wire

[hdl/crba_seq.sv]
// ----------------------------------------------------------------------------
// crba_seq
// Sequencer: reset sweep, first-fit window search, marking and freeing.
// ----------------------------------------------------------------------------
`default_nettype none

module crba_seq
   import crba_pkg::*;
#(
   parameter int BLOCK_SIZE_LOG = DEF_BLOCK_SIZE_LOG,
   parameter int NUM_BLOCKS     = DEF_NUM_BLOCKS,
   localparam int IDX_W = $clog2(NUM_BLOCKS)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_type,
   input  wire logic [31:0]      req_size_bytes,
   input  wire logic [31:0]      req_base_address,
   output mem_ctl_type           mem_ctl,
   output logic [IDX_W-1:0]      mem_addr,
   input  wire logic             mem_rd_bit,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output logic [31:0]           res_addr,
   output logic [1:0]            res_status
);

   localparam int ABLK_W = 32 - BLOCK_SIZE_LOG;
   localparam int CNT_W  = ABLK_W + 1;
   localparam int POS_W  = (IDX_W + 1 > ABLK_W + 2) ? IDX_W + 1 : ABLK_W + 2;
   localparam longint ADDR_BLOCKS = longint'(1) << ABLK_W;
   localparam longint LIMIT = (longint'(NUM_BLOCKS) < ADDR_BLOCKS) ?
                              longint'(NUM_BLOCKS) : ADDR_BLOCKS;
   localparam logic [POS_W-1:0] LIMIT_P = POS_W'(LIMIT);
   localparam logic [POS_W-1:0] NUM_P   = POS_W'(NUM_BLOCKS);

   seq_state_type     state_ff, state_in;
   logic [POS_W-1:0]  first_ff, first_in;
   logic [POS_W-1:0]  test_ff, test_in;
   logic [POS_W-1:0]  last_ff, last_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [1:0]        status_ff, status_in;

   logic [POS_W-1:0]  win_end;
   logic [CNT_W-1:0]  req_count;

   // window end is the one shared add; the fit check compares against it
   assign win_end = first_ff + POS_W'(count_ff);

   assign req_count = CNT_W'(req_size_bytes[31:BLOCK_SIZE_LOG])
                    + CNT_W'(|req_size_bytes[BLOCK_SIZE_LOG-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      first_ff  <= first_in;
      test_ff   <= test_in;
      last_ff   <= last_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      first_in  = first_ff;
      test_in   = test_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      clr_in    = clr_ff;
      status_in = status_ff;
      mem_ctl   = '0;
      mem_addr  = '0;
      req_stall = 1'b1;
      res_valid = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_ctl.wr_en  = 1'b1;
            mem_ctl.wr_bit = (clr_ff < IDX_W'(FIRST_FREE_BLOCK));
            mem_addr       = clr_ff;
            clr_in         = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               count_in = req_count;
               if (req_type == REQ_ALLOC) begin
                  first_in = POS_W'(FIRST_FREE_BLOCK);
                  state_in = S_WINDOW;
               end else begin
                  first_in = POS_W'(req_base_address[31:BLOCK_SIZE_LOG]);
                  state_in = S_FREE;
               end
            end
         end
         S_WINDOW: begin
            if (count_ff == '0 || win_end > LIMIT_P) begin
               status_in = ST_NO_FIT;
               state_in  = S_DONE;
            end else begin
               // probe the window from its last block down
               test_in       = win_end - 1'b1;
               last_in       = win_end - 1'b1;
               mem_ctl.rd_en = 1'b1;
               mem_addr      = test_in[IDX_W-1:0];
               state_in      = S_PROBE;
            end
         end
         S_PROBE: begin
            if (mem_rd_bit) begin
               first_in = test_ff + 1'b1;
               state_in = S_WINDOW;
            end else if (test_ff == first_ff) begin
               state_in = S_MARK;
            end else begin
               test_in       = test_ff - 1'b1;
               mem_ctl.rd_en = 1'b1;
               mem_addr      = test_in[IDX_W-1:0];
            end
         end
         S_MARK: begin
            mem_ctl.wr_en  = 1'b1;
            mem_ctl.wr_bit = 1'b1;
            mem_addr       = test_ff[IDX_W-1:0];
            test_in        = test_ff + 1'b1;
            if (test_ff == last_ff) begin
               status_in = ST_ALLOC_OK;
               state_in  = S_DONE;
            end
         end
         S_FREE: begin
            if (count_ff == '0 || first_ff >= NUM_P) begin
               status_in = ST_FREE_DONE;
               state_in  = S_DONE;
            end else begin
               mem_ctl.wr_en  = 1'b1;
               mem_ctl.wr_bit = 1'b0;
               mem_addr       = first_ff[IDX_W-1:0];
               first_in       = first_ff + 1'b1;
               count_in       = count_ff - 1'b1;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_status = status_ff;
   assign res_addr   = (status_ff == ST_ALLOC_OK) ?
                       {first_ff[ABLK_W-1:0], {BLOCK_SIZE_LOG{1'b0}}} : 32'd0;

endmodule

`default_nettype wire

[hdl/contiguous_block_run_allocator_core.sv]
// ----------------------------------------------------------------------------
// contiguous_block_run_allocator_core
// First-fit allocator of contiguous block runs over a busy bitmap.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap once, one block per cycle,
// marking blocks 0 and 1 busy; no request is taken until the sweep ends.
// Each request then runs one at a time through a sequencer built around a
// single-port bitmap memory, which reads or writes one block per cycle. An
// allocate is accepted, checks each candidate window, probes its blocks from
// the last one down, marks the blocks of the window that fits, and answers;
// the worst case walks most of the map. A zero-size allocate, or one too
// large for the searchable blocks, answers without probing. A free clears
// its blocks in turn and then answers. The result sits in an output register,
// so the next request is accepted while a result still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "contiguous_block_run_allocator_core_defines.svh"

module contiguous_block_run_allocator_core
   import crba_pkg::*;
#(
   parameter int BLOCK_SIZE_LOG = DEF_BLOCK_SIZE_LOG,
   parameter int NUM_BLOCKS     = DEF_NUM_BLOCKS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [31:0] req_size_bytes,
   input  wire logic [31:0] req_base_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_run_address,
   output logic [1:0]       rsp_status
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);

   mem_ctl_type       mem_ctl;
   logic [IDX_W-1:0]  mem_addr;
   logic              mem_rd_bit;
   logic              res_valid;
   logic              res_ready;
   logic [31:0]       res_addr;
   logic [1:0]        res_status;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   crba_seq #(
      .BLOCK_SIZE_LOG (BLOCK_SIZE_LOG),
      .NUM_BLOCKS     (NUM_BLOCKS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_size_bytes   (req_size_bytes),
      .req_base_address (req_base_address),
      .mem_ctl          (mem_ctl),
      .mem_addr         (mem_addr),
      .mem_rd_bit       (mem_rd_bit),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res_addr         (res_addr),
      .res_status       (res_status)
   );

   crba_bitmap #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_bitmap (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_rd_bit (mem_rd_bit)
   );

   // output register frees up as the current result transfers
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_addr_in   = res_addr;
            rsp_status_in = res_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_run_address = rsp_addr_ff;
   assign rsp_status      = rsp_status_ff;

   `CRBA_ASSERT_IMP(a_alloc_addr, clock, reset,
      rsp_valid && rsp_status == ST_ALLOC_OK,
      rsp_run_address != 32'd0 && rsp_run_address[BLOCK_SIZE_LOG-1:0] == '0,
      "allocated address is zero or not block aligned")
   `CRBA_ASSERT_IMP(a_noalloc_zero, clock, reset,
      rsp_valid && rsp_status != ST_ALLOC_OK,
      rsp_run_address == 32'd0,
      "failed or free result carries a nonzero address")
   `CRBA_ASSERT_NXT(a_busy_after_accept, clock, reset,
      req_valid && !req_stall,
      req_stall,
      "request accepted while previous one still in progress")

endmodule

`default_nettype wire
